@@ src/bpl_pkg.sv @@
package bpl_pkg;

  localparam int CAPACITY = 27;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int POS_W    = 6;
  localparam int BYTE_W   = 8;
  localparam int MODE_W   = 2;

  localparam int IN_TDATA_W  = 2 * BYTE_W;
  localparam int OUT_TDATA_W = 8;

  localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_APPEND = 2'd1;
  localparam logic [MODE_W-1:0] MODE_PUSH   = 2'd2;
  localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd3;

  localparam logic [BYTE_W-1:0] RESERVED_VARIANT = 8'hFE;
  localparam logic [POS_W-1:0]  POS_REJECT       = 6'h3F;

  typedef struct packed {
    logic              capture;
    logic              shift_en;
    logic              append_en;
    logic [CNT_W-1:0]  count;
    logic [BYTE_W-1:0] kind;
    logic [BYTE_W-1:0] variant;
  } cell_ctl_t;

endpackage

@@ src/bpl_cell.sv @@
module bpl_cell
  import bpl_pkg::*;
(
  input  logic              clk,
  input  cell_ctl_t         ctl,
  input  logic [CNT_W-1:0]  cell_idx,
  input  logic [BYTE_W-1:0] prev_kind,
  input  logic [BYTE_W-1:0] prev_variant,
  output logic [BYTE_W-1:0] kind_q,
  output logic [BYTE_W-1:0] variant_q,
  output logic              match_q
);

  logic [BYTE_W-1:0] kind_r;
  logic [BYTE_W-1:0] variant_r;
  logic              match_r;
  logic              write_here;
  logic              occupied;

  assign write_here = ctl.append_en && (ctl.count == cell_idx);
  assign occupied   = cell_idx < ctl.count;

  always_ff @(posedge clk) begin
    if (ctl.shift_en) begin
      kind_r    <= prev_kind;
      variant_r <= prev_variant;
    end else if (write_here) begin
      kind_r    <= ctl.kind;
      variant_r <= ctl.variant;
    end
    // compare against the contents before this transfer updates them
    if (ctl.capture) begin
      match_r <= occupied && (kind_r == ctl.kind) && (variant_r == ctl.variant);
    end
  end

  assign kind_q    = kind_r;
  assign variant_q = variant_r;
  assign match_q   = match_r;

endmodule

@@ src/bounded_pair_list_core.sv @@
// Ordered list of up to CAPACITY (kind, variant) pairs held in a row of cells.
// in_tuser carries the operation: clear, append at tail, push at front, lookup.
// Each accepted item gives exactly one result. At the item's transfer edge
// every cell shifts, loads or compares against the request; once the output
// register is free (empty or being read), the match flags are folded into it.
// A single evaluation stage holds the item, so at most one item is in flight
// and a new item is not taken until the previous one has left that stage;
// the next item may be accepted while the previous result still waits in the
// output register.
// Appending or pushing onto a full list, or with variant 0xFE, returns
// position 0x3F and leaves the list unchanged. Lookups miss while list_active
// (cfg_data) is 0. Configuration is taken at once (cfg_ready is high outside
// reset); in_tready and cfg_ready stay low while rst_n is low.
module bounded_pair_list_core
  import bpl_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // kind[7:0], variant[15:8]
  input  logic [MODE_W-1:0]      in_tuser,   // mode[1:0]
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // position[5:0], hit[6], zero[7]
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic                   cfg_data    // list_active
);

  logic [BYTE_W-1:0] in_kind;
  logic [BYTE_W-1:0] in_variant;
  logic [MODE_W-1:0] in_mode;
  logic              accept;
  logic              ins_ok;
  logic              done;

  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              busy_r, busy_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              active_r;
  logic [POS_W-1:0]  pend_pos_r, pend_pos_nxt;
  logic              pend_lookup_r;
  logic [POS_W-1:0]  out_pos_r;
  logic              out_hit_r;

  cell_ctl_t         ctl;
  logic [BYTE_W-1:0] kind_q    [CAPACITY];
  logic [BYTE_W-1:0] variant_q [CAPACITY];
  logic [CAPACITY-1:0] match_q;

  assign in_kind    = in_tdata[BYTE_W-1:0];
  assign in_variant = in_tdata[2*BYTE_W-1:BYTE_W];
  assign in_mode    = in_tuser;

  assign in_tready = rst_n && !busy_r;
  assign accept    = in_tvalid && in_tready;
  assign cfg_ready = rst_n;
  assign done      = busy_r && (!out_valid_r || out_tready);

  assign ins_ok = (count_r < CNT_W'(CAPACITY)) && (in_variant != RESERVED_VARIANT);

  always_comb begin
    ctl.capture   = accept;
    ctl.shift_en  = accept && (in_mode == MODE_PUSH) && ins_ok;
    ctl.append_en = accept && (in_mode == MODE_APPEND) && ins_ok;
    ctl.count     = count_r;
    ctl.kind      = in_kind;
    ctl.variant   = in_variant;
  end

  genvar gi;
  generate
    for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
      logic [BYTE_W-1:0] prev_kind;
      logic [BYTE_W-1:0] prev_variant;
      if (gi == 0) begin : g_head
        assign prev_kind    = in_kind;
        assign prev_variant = in_variant;
      end else begin : g_body
        assign prev_kind    = kind_q[gi-1];
        assign prev_variant = variant_q[gi-1];
      end
      bpl_cell u_cell (
        .clk          (clk),
        .ctl          (ctl),
        .cell_idx     (CNT_W'(gi)),
        .prev_kind    (prev_kind),
        .prev_variant (prev_variant),
        .kind_q       (kind_q[gi]),
        .variant_q    (variant_q[gi]),
        .match_q      (match_q[gi])
      );
    end
  endgenerate

  always_comb begin
    count_nxt    = count_r;
    pend_pos_nxt = '0;
    unique case (in_mode)
      MODE_CLEAR: begin
        count_nxt = '0;
      end
      MODE_APPEND: begin
        if (ins_ok) begin
          pend_pos_nxt = POS_W'(count_r);
          count_nxt    = CNT_W'(count_r + 1'b1);
        end else begin
          pend_pos_nxt = POS_REJECT;
        end
      end
      MODE_PUSH: begin
        if (ins_ok) begin
          pend_pos_nxt = POS_W'(count_r + 1'b1);
          count_nxt    = CNT_W'(count_r + 1'b1);
        end else begin
          pend_pos_nxt = POS_REJECT;
        end
      end
      default: begin
        pend_pos_nxt = '0;
      end
    endcase
  end

  always_comb begin
    busy_nxt = busy_r;
    if (accept) begin
      busy_nxt = 1'b1;
    end else if (done) begin
      busy_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (done) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
      active_r    <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
      if (accept) begin
        count_r <= count_nxt;
      end
      if (cfg_valid && cfg_ready) begin
        active_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pend_pos_r    <= pend_pos_nxt;
      pend_lookup_r <= (in_mode == MODE_LOOKUP);
    end
    if (done) begin
      out_pos_r <= pend_pos_r;
      out_hit_r <= pend_lookup_r && active_r && (|match_q);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_hit_r, out_pos_r};

endmodule

@@ src/bpl_checker.sv @@
module bpl_checker
  import bpl_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic [IN_TDATA_W-1:0]  in_tdata,
  input logic [MODE_W-1:0]      in_tuser,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // a hit only comes from a lookup, which reports position zero
  a_hit_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[POS_W] |-> out_tdata[POS_W-1:0] == '0)
    else $error("hit with nonzero position");

  // one item in flight at a time
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second item accepted while busy");

  // with no result waiting at the transfer, the result is registered straight after the evaluation stage
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !out_tvalid |=> ##1 out_tvalid)
    else $error("result did not appear in time");

  // the reserved variant is never stored
  a_reject: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !out_tvalid && in_tuser == MODE_APPEND &&
    in_tdata[2*BYTE_W-1:BYTE_W] == RESERVED_VARIANT
    |=> ##1 out_tdata[POS_W-1:0] == POS_REJECT)
    else $error("reserved variant accepted for append");

endmodule

bind bounded_pair_list_core bpl_checker u_bpl_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

@@ tb/sv/bounded_pair_list_core_tb.sv @@
`timescale 1ns / 1ps

module bounded_pair_list_core_tb;
  import bpl_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 4;

  typedef struct {
    logic signed [POS_W-1:0] position;
    logic                    hit;
  } list_result_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;   // kind[7:0], variant[15:8]
  logic [MODE_W-1:0]      in_tuser = MODE_CLEAR;   // mode[1:0]
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;  // position[5:0], hit[6], zero[7]
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic                   cfg_data = 1'b0;   // list_active

  // shadow copy of the list
  logic [BYTE_W-1:0] shadow_kind [CAPACITY];
  logic [BYTE_W-1:0] shadow_variant [CAPACITY];
  int                shadow_count = 0;
  logic              shadow_active = 1'b0;

  list_result_t pending_results[$];
  int           mismatch_count = 0;
  int           src_idle_pct = 0;
  int           sink_idle_pct = 0;
  int           sink_hold_request = 0;
  int           sink_hold_left = 0;
  int           quiet_cycles = 0;

  bounded_pair_list_core u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always #10 clk = ~clk;

  function automatic list_result_t predict_list_op(input logic [MODE_W-1:0] mode,
                                                   input logic [BYTE_W-1:0] kind,
                                                   input logic [BYTE_W-1:0] variant);
    list_result_t res;
    logic         room;
    res.position = '0;
    res.hit = 1'b0;
    room = (shadow_count < CAPACITY) && (variant != RESERVED_VARIANT);
    case (mode)
      MODE_CLEAR: begin
        shadow_count = 0;
      end
      MODE_APPEND: begin
        if (room) begin
          shadow_kind[shadow_count] = kind;
          shadow_variant[shadow_count] = variant;
          res.position = POS_W'(shadow_count);
          shadow_count++;
        end else begin
          res.position = POS_REJECT;
        end
      end
      MODE_PUSH: begin
        if (room) begin
          for (int i = shadow_count; i > 0; i--) begin
            shadow_kind[i] = shadow_kind[i-1];
            shadow_variant[i] = shadow_variant[i-1];
          end
          shadow_kind[0] = kind;
          shadow_variant[0] = variant;
          shadow_count++;
          res.position = POS_W'(shadow_count);
        end else begin
          res.position = POS_REJECT;
        end
      end
      default: begin
        if (shadow_active) begin
          for (int i = 0; i < shadow_count; i++) begin
            if (shadow_kind[i] == kind && shadow_variant[i] == variant) res.hit = 1'b1;
          end
        end
      end
    endcase
    return res;
  endfunction

  // result check first: a result taken at this edge belongs to an earlier item
  always @(posedge clk) begin
    list_result_t want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (pending_results.size() == 0) begin
          $error("result with nothing pending: out_tdata %h", out_tdata);
          mismatch_count++;
        end else begin
          want = pending_results.pop_front();
          if ($signed(out_tdata[POS_W-1:0]) !== want.position) begin
            $error("position: expected %0d actual %0d", want.position,
                   $signed(out_tdata[POS_W-1:0]));
            mismatch_count++;
          end
          if (out_tdata[POS_W] !== want.hit) begin
            $error("hit: expected %0d actual %0d", want.hit, out_tdata[POS_W]);
            mismatch_count++;
          end
        end
      end
      if (in_tvalid && in_tready)
        pending_results.push_back(predict_list_op(in_tuser, in_tdata[BYTE_W-1:0],
                                                  in_tdata[2*BYTE_W-1:BYTE_W]));
      if (cfg_valid && cfg_ready) shadow_active = cfg_data;
    end
  end

  // result side: random stalls plus a long hold-off on request
  always @(posedge clk) begin
    if (sink_hold_request != 0) begin
      sink_hold_left = sink_hold_request;
      sink_hold_request = 0;
    end
    if (sink_hold_left > 0) begin
      sink_hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic send_item(input logic [MODE_W-1:0] mode, input logic [BYTE_W-1:0] kind,
                           input logic [BYTE_W-1:0] variant);
    while ($urandom_range(99) < src_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= mode;
    in_tdata <= {variant, kind};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic wait_list_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_list_active(input logic active);
    wait_list_idle();
    cfg_valid <= 1'b1;
    cfg_data <= active;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_random_item(input int clear_pct);
    logic [MODE_W-1:0] mode;
    logic [BYTE_W-1:0] kind;
    logic [BYTE_W-1:0] variant;
    int                pick;
    int                idx;
    pick = $urandom_range(99);
    if (pick < clear_pct) mode = MODE_CLEAR;
    else if (pick < 40) mode = MODE_APPEND;
    else if (pick < 62) mode = MODE_PUSH;
    else mode = MODE_LOOKUP;
    // narrow values half the time so lookups find near misses and hits
    kind = ($urandom_range(1) == 1) ? BYTE_W'($urandom_range(3)) : BYTE_W'($urandom);
    pick = $urandom_range(99);
    if (pick < 6) variant = RESERVED_VARIANT;
    else if (pick < 50) variant = BYTE_W'($urandom_range(5)) - 8'd3;
    else variant = BYTE_W'($urandom);
    if (mode == MODE_LOOKUP && shadow_count > 0 && $urandom_range(99) < 50) begin
      idx = $urandom_range(shadow_count - 1);
      kind = shadow_kind[idx];
      variant = shadow_variant[idx];
    end
    send_item(mode, kind, variant);
  endtask

  task automatic test_lookup_detached();
    send_item(MODE_APPEND, 8'd5, 8'd9);
    send_item(MODE_LOOKUP, 8'd5, 8'd9);
    send_item(MODE_LOOKUP, 8'd5, RESERVED_VARIANT);
  endtask

  task automatic test_directed_ops();
    write_list_active(1'b1);
    send_item(MODE_CLEAR, 8'd0, 8'd0);
    send_item(MODE_APPEND, 8'd0, 8'h80);
    send_item(MODE_APPEND, 8'hFF, 8'h7F);
    send_item(MODE_PUSH, 8'h80, 8'h00);
    send_item(MODE_LOOKUP, 8'hFF, 8'h7F);
    send_item(MODE_LOOKUP, 8'hFF, 8'h7E);
    send_item(MODE_LOOKUP, 8'h80, 8'h00);
    send_item(MODE_APPEND, 8'd1, RESERVED_VARIANT);
    send_item(MODE_PUSH, 8'd1, RESERVED_VARIANT);
    send_item(MODE_LOOKUP, 8'd1, RESERVED_VARIANT);
    send_item(MODE_LOOKUP, 8'd0, 8'h80);
    send_item(MODE_CLEAR, 8'hFF, 8'hFF);
    send_item(MODE_LOOKUP, 8'd0, 8'h80);
  endtask

  task automatic test_full_list();
    send_item(MODE_CLEAR, 8'd0, 8'd0);
    for (int i = 0; i < CAPACITY; i++)
      send_item((i % 3 == 0) ? MODE_PUSH : MODE_APPEND, BYTE_W'(i * 9), BYTE_W'(i + 13));
    send_item(MODE_APPEND, 8'hAA, 8'h55);
    send_item(MODE_PUSH, 8'hAA, 8'h55);
    send_item(MODE_LOOKUP, shadow_kind[CAPACITY-1], shadow_variant[CAPACITY-1]);
    send_item(MODE_LOOKUP, shadow_kind[0], shadow_variant[0]);
    send_item(MODE_LOOKUP, 8'hAA, 8'h55);
    send_item(MODE_CLEAR, 8'd0, 8'd0);
  endtask

  task automatic test_random_phase(input int src_pct, input int sink_pct, input logic active,
                                   input int count);
    write_list_active(active);
    src_idle_pct = src_pct;
    sink_idle_pct = sink_pct;
    for (int i = 0; i < count; i++) send_random_item(3);
  endtask

  task automatic test_backpressure();
    src_idle_pct = 0;
    sink_idle_pct = 0;
    sink_hold_request = 200;
    for (int i = 0; i < 40; i++) send_random_item(0);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_lookup_detached();
    test_directed_ops();
    test_full_list();
    test_random_phase(9, 55, 1'b1, 250);
    test_random_phase(55, 9, 1'b0, 250);
    test_random_phase(0, 0, 1'b1, 250);
    test_backpressure();
    wait_list_idle();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
